// ===== design/drt_pkg.sv =====
`timescale 1ns / 1ps
package drt_pkg;
    localparam int LAYERS     = 4;
    localparam int SLOTS      = 32;
    localparam int COORD_BITS = 12;
    localparam int LAYER_W    = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int ADDR_W     = LAYER_W + SLOT_W;
    localparam int DEPTH      = LAYERS * SLOTS;
    localparam int CNT_W      = SLOT_W + 1;
    localparam int DIM_W      = COORD_BITS + 1;

    localparam logic [1:0] FUNC_MARK  = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_FLUSH = 2'd2;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0] x0;
        logic [COORD_BITS-1:0] y0;
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] y1;
    } t_rect;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLR, ST_MREAD, ST_MCHK, ST_FREAD, ST_FCHK, ST_LREAD, ST_LCHK,
        ST_OREAD, ST_OUT
    } t_state;

    function automatic logic overlaps(t_rect a, t_rect b);
        return !(b.x1 < a.x0 || b.x0 > a.x1 || b.y1 < a.y0 || b.y0 > a.y1);
    endfunction

    function automatic t_rect grow(t_rect a, t_rect b);
        t_rect r;
        r.x0 = (b.x0 < a.x0) ? b.x0 : a.x0;
        r.y0 = (b.y0 < a.y0) ? b.y0 : a.y0;
        r.x1 = (b.x1 > a.x1) ? b.x1 : a.x1;
        r.y1 = (b.y1 > a.y1) ? b.y1 : a.y1;
        return r;
    endfunction
endpackage

// ===== design/dirty_rectangle_tracker_top.sv =====
`timescale 1ns / 1ps
// Dirty-rectangle tracker: per-layer tables of damage rectangles in one
// synchronous slot memory, plus a merge list memory used by a flush. A mark
// reads one slot at a time, a read state then a check state per slot, until
// it merges or reaches the last slot of its layer. A clear is written in the
// cycle of its transfer and keeps the input open. A flush reads every slot of
// every layer; each valid slot is cleared and compared with the held list
// entries, merged into the first that it overlaps or else appended while
// the list has room. After that it emits the list entries in order, holding
// on any output stall.
// After reset a clearing pass runs over every slot of the slot
// memory before the first item is taken. Results leave through an output
// register that holds while i_stall is high; the input stalls while busy.
module dirty_rectangle_tracker_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_func,
    input  logic [1:0]                     i_layer_sel,
    input  logic [drt_pkg::COORD_BITS-1:0] i_x_coord,
    input  logic [drt_pkg::COORD_BITS-1:0] i_y_coord,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [drt_pkg::COORD_BITS-1:0] o_rect_x_min,
    output logic [drt_pkg::COORD_BITS-1:0] o_rect_y_min,
    output logic [drt_pkg::COORD_BITS-1:0] o_rect_x_max,
    output logic [drt_pkg::COORD_BITS-1:0] o_rect_y_max,
    output logic                           o_last_rect,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [12:0]                    i_cfg_data
);
    localparam int AW = drt_pkg::ADDR_W;
    localparam int SW = drt_pkg::SLOT_W;
    localparam int CW = drt_pkg::CNT_W;
    localparam int DW = drt_pkg::DIM_W;
    localparam int CB = drt_pkg::COORD_BITS;

    // storage
    logic [$bits(drt_pkg::t_rect):0] slot_mem [drt_pkg::DEPTH];
    drt_pkg::t_rect                  list_mem [drt_pkg::SLOTS];

    drt_pkg::t_state r_state, n_state;
    logic [12:0]     r_width, r_height;
    logic [AW-1:0]   r_addr, n_addr;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_j, n_j;
    logic [drt_pkg::LAYER_W-1:0] r_layer, n_layer;
    drt_pkg::t_rect  r_cur, n_cur;
    logic [$bits(drt_pkg::t_rect):0] r_slot_rd;
    drt_pkg::t_rect  r_list_rd;
    logic            r_ov, n_ov;
    drt_pkg::t_rect  r_out, n_out;
    logic            r_last, n_last;

    // memory control
    logic            s_we;
    logic [AW-1:0]   s_waddr, s_raddr;
    logic [$bits(drt_pkg::t_rect):0] s_wdata;
    logic            l_we;
    logic [SW-1:0]   l_waddr, l_raddr;
    drt_pkg::t_rect  l_wdata;

    // saturated screen size
    logic [DW-1:0] w_sat, h_sat;
    always_comb begin
        w_sat = (r_width == '0) ? DW'(1) :
                (r_width > DW'(1 << CB)) ? DW'(1 << CB) : r_width[DW-1:0];
        h_sat = (r_height == '0) ? DW'(1) :
                (r_height > DW'(1 << CB)) ? DW'(1 << CB) : r_height[DW-1:0];
    end

    // padded point rectangle
    drt_pkg::t_rect pad;
    logic [DW-1:0]  xp1, yp1;
    always_comb begin
        xp1 = {1'b0, i_x_coord} + DW'(1);
        yp1 = {1'b0, i_y_coord} + DW'(1);
        pad.x0 = (i_x_coord != '0) ? i_x_coord - CB'(1) : '0;
        pad.y0 = (i_y_coord != '0) ? i_y_coord - CB'(1) : '0;
        pad.x1 = (xp1 >= w_sat) ? CB'(w_sat - DW'(1)) : CB'(xp1);
        pad.y1 = (yp1 >= h_sat) ? CB'(h_sat - DW'(1)) : CB'(yp1);
    end

    logic          in_xfer, out_xfer, out_free;
    drt_pkg::t_rect slot_r;
    logic          slot_v;
    logic [SW-1:0] slot_idx;
    logic          slot_last, layer_last;
    assign in_xfer   = i_valid && !o_stall;
    assign out_xfer  = o_valid && !i_stall;
    assign out_free  = !o_valid || !i_stall;
    assign slot_r    = r_slot_rd[$bits(drt_pkg::t_rect)-1:0];
    assign slot_v    = r_slot_rd[$bits(drt_pkg::t_rect)];
    assign slot_idx  = r_addr[SW-1:0];
    assign slot_last = (slot_idx == SW'(drt_pkg::SLOTS - 1));
    assign layer_last = (r_addr[AW-1:SW] == (AW - SW)'(drt_pkg::LAYERS - 1));
    assign o_stall   = (r_state != drt_pkg::ST_IDLE);
    assign o_cfg_ready = (r_state == drt_pkg::ST_IDLE);

    // sequencer
    always_comb begin
        n_state = r_state; n_addr = r_addr; n_cnt = r_cnt; n_j = r_j;
        n_layer = r_layer; n_cur = r_cur; n_ov = r_ov; n_out = r_out;
        n_last = r_last;
        s_we = 1'b0; s_waddr = r_addr; s_raddr = r_addr;
        s_wdata = {1'b0, r_cur};
        l_we = 1'b0; l_waddr = r_cnt[SW-1:0]; l_raddr = r_j[SW-1:0];
        l_wdata = r_cur;
        if (out_xfer) n_ov = 1'b0;
        case (r_state)
            drt_pkg::ST_CLR: begin
                s_we = 1'b1; s_wdata = '0;
                n_addr = r_addr + AW'(1);
                if (r_addr == AW'(drt_pkg::DEPTH - 1)) n_state = drt_pkg::ST_IDLE;
            end
            drt_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (i_func == drt_pkg::FUNC_FLUSH) begin
                        n_addr = '0; n_cnt = '0; n_state = drt_pkg::ST_FREAD;
                    end else if ({1'b0, i_layer_sel} < 3'(drt_pkg::LAYERS)) begin
                        n_layer = drt_pkg::LAYER_W'(i_layer_sel);
                        n_addr = {drt_pkg::LAYER_W'(i_layer_sel), SW'(0)};
                        if (i_func == drt_pkg::FUNC_CLEAR) begin
                            s_we = 1'b1;
                            s_waddr = {drt_pkg::LAYER_W'(i_layer_sel), SW'(0)};
                            s_wdata = {1'b1, CB'(0), CB'(0),
                                       CB'(w_sat - DW'(1)), CB'(h_sat - DW'(1))};
                        end else if (i_func == drt_pkg::FUNC_MARK &&
                                     {1'b0, i_x_coord} < w_sat &&
                                     {1'b0, i_y_coord} < h_sat) begin
                            n_cur = pad; n_j = '0; n_state = drt_pkg::ST_MREAD;
                        end
                    end
                end
            end
            // mark pass 1: merge into first overlapping slot; r_j marks a free slot found
            drt_pkg::ST_MREAD: n_state = drt_pkg::ST_MCHK;
            drt_pkg::ST_MCHK: begin
                if (slot_v && drt_pkg::overlaps(slot_r, r_cur)) begin
                    s_we = 1'b1; s_wdata = {1'b1, drt_pkg::grow(slot_r, r_cur)};
                    n_state = drt_pkg::ST_IDLE;
                end else begin
                    if (!slot_v && !r_j[SW]) begin
                        n_j = {1'b1, slot_idx};
                    end
                    if (slot_last) begin
                        n_state = drt_pkg::ST_IDLE;
                        if (!slot_v && !r_j[SW]) begin
                            s_we = 1'b1; s_wdata = {1'b1, r_cur};
                        end else if (r_j[SW]) begin
                            s_we = 1'b1; s_waddr = {r_layer, r_j[SW-1:0]};
                            s_wdata = {1'b1, r_cur};
                        end
                    end else begin
                        n_addr = r_addr + AW'(1); n_state = drt_pkg::ST_MREAD;
                    end
                end
            end
            // flush: read slot, then scan merge list
            drt_pkg::ST_FREAD: n_state = drt_pkg::ST_FCHK;
            drt_pkg::ST_FCHK: begin
                n_cur = slot_r; n_j = '0;
                if (slot_v) begin
                    s_we = 1'b1; s_wdata = '0;
                    n_state = drt_pkg::ST_LREAD;
                end else if (slot_last && layer_last) begin
                    n_j = '0;
                    n_state = (r_cnt == '0) ? drt_pkg::ST_IDLE : drt_pkg::ST_OREAD;
                end else begin
                    n_addr = r_addr + AW'(1); n_state = drt_pkg::ST_FREAD;
                end
            end
            drt_pkg::ST_LREAD: begin
                if (r_j == r_cnt) begin
                    if (r_cnt < CW'(drt_pkg::SLOTS)) begin
                        l_we = 1'b1; n_cnt = r_cnt + CW'(1);
                    end
                    if (slot_last && layer_last) begin
                        n_j = '0; n_state = drt_pkg::ST_OREAD;
                    end else begin
                        n_addr = r_addr + AW'(1); n_state = drt_pkg::ST_FREAD;
                    end
                end else begin
                    n_state = drt_pkg::ST_LCHK;
                end
            end
            drt_pkg::ST_LCHK: begin
                if (drt_pkg::overlaps(r_list_rd, r_cur)) begin
                    l_we = 1'b1; l_waddr = r_j[SW-1:0];
                    l_wdata = drt_pkg::grow(r_list_rd, r_cur);
                    if (slot_last && layer_last) begin
                        n_j = '0; n_state = drt_pkg::ST_OREAD;
                    end else begin
                        n_addr = r_addr + AW'(1); n_state = drt_pkg::ST_FREAD;
                    end
                end else begin
                    n_j = r_j + CW'(1); n_state = drt_pkg::ST_LREAD;
                end
            end
            // emit list through output register
            drt_pkg::ST_OREAD: n_state = drt_pkg::ST_OUT;
            drt_pkg::ST_OUT: begin
                if (out_free) begin
                    n_ov = 1'b1; n_out = r_list_rd;
                    n_last = (r_j + CW'(1) == r_cnt);
                    n_j = r_j + CW'(1);
                    n_state = n_last ? drt_pkg::ST_IDLE : drt_pkg::ST_OREAD;
                end
            end
            default: n_state = drt_pkg::ST_IDLE;
        endcase
        if (n_state == drt_pkg::ST_FREAD || n_state == drt_pkg::ST_MREAD) s_raddr = n_addr;
        l_raddr = n_j[SW-1:0];
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (s_we) slot_mem[s_waddr] <= s_wdata;
        r_slot_rd <= slot_mem[s_raddr];
        if (l_we) list_mem[l_waddr] <= l_wdata;
        r_list_rd <= list_mem[l_raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= drt_pkg::ST_CLR; r_addr <= '0; r_cnt <= '0; r_j <= '0;
            r_ov <= 1'b0; r_width <= 13'd640; r_height <= 13'd480;
        end else begin
            r_state <= n_state; r_addr <= n_addr; r_cnt <= n_cnt; r_j <= n_j;
            r_ov <= n_ov;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == drt_pkg::REG_WIDTH) r_width <= i_cfg_data;
                else r_height <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_layer <= n_layer; r_cur <= n_cur; r_out <= n_out; r_last <= n_last;
    end

    assign o_valid      = r_ov;
    assign o_rect_x_min = r_out.x0;
    assign o_rect_y_min = r_out.y0;
    assign o_rect_x_max = r_out.x1;
    assign o_rect_y_max = r_out.y1;
    assign o_last_rect  = r_last;
endmodule

// ===== design/drt_checker.sv =====
`timescale 1ns / 1ps
module drt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_last_rect,
    input logic o_cfg_ready,
    input logic [drt_pkg::COORD_BITS-1:0] o_rect_x_min,
    input logic [drt_pkg::COORD_BITS-1:0] o_rect_x_max
);
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rect_x_min))
        else $error("stalled result changed");
    // no input taken while a flush is emitting
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_rect |-> o_stall)
        else $error("input open mid flush");
    // emitted rectangles have x min at or below x max
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rect_x_min <= o_rect_x_max)
        else $error("bad rectangle");
    // config port only open while idle
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !o_stall)
        else $error("config open while busy");
endmodule

bind dirty_rectangle_tracker_top drt_checker u_drt_checker (.*);
